// ===== design/integer_matrix_alu_core_assert.svh =====
// Assertion macros shared by the integer matrix ALU modules.
`ifndef INTEGER_MATRIX_ALU_CORE_ASSERT_SVH
`define INTEGER_MATRIX_ALU_CORE_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define IMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition in one cycle leads to a property in the next.
`define IMA_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/ima_pkg.sv =====
// Shared constants, codes and types of the integer matrix ALU.
package ima_pkg;

    // Matrix store geometry.
    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int DATA_W    = 32;

    // Configuration field widths and values.
    localparam int OP_W  = 2;
    localparam int DIM_W = 5;
    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

    // APB port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_OPERATION = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 2'd2;

    // Command codes of an input item.
    localparam logic [1:0] CMD_WR_A    = 2'd0;
    localparam logic [1:0] CMD_WR_B    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Work classes decided by the front end.
    typedef enum logic [2:0] {
        KIND_WR_A,
        KIND_WR_B,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_ZERO
    } kind_t;

    // One queued item.
    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              in_range;
    } entry_t;

    // Active configuration with sizes clamped to the store.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } dims_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// ===== design/ima_front.sv =====
// Front end: accepts input items and classifies them for the back end.
module ima_front (
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [1:0]                  cmd,
    input  logic [ima_pkg::IDX_W-1:0]   row,
    input  logic [ima_pkg::IDX_W-1:0]   col,
    input  logic [ima_pkg::DATA_W-1:0]  value,
    input  ima_pkg::dims_t              dims,
    input  logic                        q_full,
    output logic                        q_push,
    output ima_pkg::entry_t             q_entry
);

    logic                  pos_ok;
    logic                  cmd_known;
    ima_pkg::kind_t        kind;
    logic [ima_pkg::DIM_W-1:0] row_ext;
    logic [ima_pkg::DIM_W-1:0] col_ext;

    // Position check against the clamped sizes.
    assign row_ext = {{(ima_pkg::DIM_W - ima_pkg::IDX_W){1'b0}}, row};
    assign col_ext = {{(ima_pkg::DIM_W - ima_pkg::IDX_W){1'b0}}, col};
    assign pos_ok  = (row_ext < dims.rows) && (col_ext < dims.cols);

    // Classify the item; unknown commands are taken and dropped.
    always_comb
    begin
        cmd_known = 1'b1;
        kind      = ima_pkg::KIND_ZERO;
        unique case (cmd)
            ima_pkg::CMD_WR_A: kind = ima_pkg::KIND_WR_A;
            ima_pkg::CMD_WR_B: kind = ima_pkg::KIND_WR_B;
            ima_pkg::CMD_COMPUTE:
            begin
                if (pos_ok)
                begin
                    unique case (dims.op)
                        ima_pkg::OP_ADD: kind = ima_pkg::KIND_ADD;
                        ima_pkg::OP_SUB: kind = ima_pkg::KIND_SUB;
                        ima_pkg::OP_MUL: kind = ima_pkg::KIND_MUL;
                        default:         kind = ima_pkg::KIND_ZERO;
                    endcase
                end
            end
            default: cmd_known = 1'b0;
        endcase
    end

    // Hand the classified item to the queue.
    assign item_ready       = !q_full;
    assign q_push           = item_valid && !q_full && cmd_known;
    assign q_entry.kind     = kind;
    assign q_entry.row      = row;
    assign q_entry.col      = col;
    assign q_entry.value    = value;
    assign q_entry.in_range = pos_ok;

endmodule

// ===== design/ima_queue.sv =====
// Short queue of classified items between the front and back ends.
`include "integer_matrix_alu_core_assert.svh"

module ima_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ima_pkg::entry_t entry_in,
    output logic            full,
    output logic            valid,
    output ima_pkg::entry_t entry_out,
    input  logic            pop
);

    ima_pkg::entry_t                entries_reg [ima_pkg::QUEUE_DEPTH];
    logic [ima_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ima_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ima_pkg::QCNT_W-1:0]     count_reg;
    logic [ima_pkg::QCNT_W-1:0]     count_next;

    // Status toward both sides.
    assign full      = (count_reg == ima_pkg::QCNT_W'(ima_pkg::QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign entry_out = entries_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= entry_in;
        end
    end

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `IMA_ASSERT(q_no_overflow, push |-> !full, "Item pushed into a full queue.")
    `IMA_ASSERT(q_no_underflow, pop |-> valid, "Item popped from an empty queue.")
    `IMA_ASSERT(q_empty_ptrs, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "Queue pointers differ while empty.")

endmodule

// ===== design/ima_back.sv =====
// Back end: matrix stores, sequencer and the shared multiply-accumulate unit.
`include "integer_matrix_alu_core_assert.svh"

module ima_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  ima_pkg::entry_t            q_entry,
    output logic                       q_pop,
    input  logic [ima_pkg::DIM_W-1:0]  cols,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [ima_pkg::DATA_W-1:0] result,
    output logic                       in_range
);

    // Matrix stores.
    logic [ima_pkg::DATA_W-1:0] mem_a [ima_pkg::MEM_DEPTH];
    logic [ima_pkg::DATA_W-1:0] mem_b [ima_pkg::MEM_DEPTH];

    // Sequencer state.
    ima_pkg::state_t            state_reg;
    ima_pkg::state_t            state_next;
    logic [ima_pkg::IDX_W-1:0]  k_reg;
    logic [ima_pkg::IDX_W-1:0]  k_next;
    logic [ima_pkg::DIM_W-1:0]  k_ext;

    // Item being computed.
    ima_pkg::kind_t             kind_reg;
    logic [ima_pkg::IDX_W-1:0]  row_reg;
    logic [ima_pkg::IDX_W-1:0]  col_reg;
    logic                       rng_reg;

    // Datapath pipeline.
    logic                       s1_vld_reg;
    logic                       s1_last_reg;
    logic                       s2_vld_reg;
    logic                       s2_last_reg;
    logic [ima_pkg::DATA_W-1:0] a_rd_reg;
    logic [ima_pkg::DATA_W-1:0] b_rd_reg;
    logic [ima_pkg::DATA_W-1:0] prod_reg;
    logic [ima_pkg::DATA_W-1:0] acc_reg;

    // Output register.
    logic                       out_vld_reg;
    logic [ima_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_rng_reg;

    // Control strobes.
    logic                        wr_a;
    logic                        wr_b;
    logic                        rd_en;
    logic                        rd_last;
    logic                        load_item;
    logic                        load_out;
    logic [ima_pkg::ADDR_W-1:0]  wr_addr;
    logic [ima_pkg::ADDR_W-1:0]  a_addr;
    logic [ima_pkg::ADDR_W-1:0]  b_addr;

    assign k_ext   = {{(ima_pkg::DIM_W - ima_pkg::IDX_W){1'b0}}, k_reg};
    assign wr_addr = {q_entry.row, q_entry.col};

    // The product walks row of A and column of B; add and subtract read one element.
    assign a_addr = (kind_reg == ima_pkg::KIND_MUL) ? {row_reg, k_reg} : {row_reg, col_reg};
    assign b_addr = (kind_reg == ima_pkg::KIND_MUL) ? {k_reg, col_reg} : {row_reg, col_reg};

    // Next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        q_pop      = 1'b0;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        rd_en      = 1'b0;
        rd_last    = 1'b0;
        load_item  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ima_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.kind)
                        ima_pkg::KIND_WR_A: wr_a = 1'b1;
                        ima_pkg::KIND_WR_B: wr_b = 1'b1;
                        ima_pkg::KIND_ADD, ima_pkg::KIND_SUB, ima_pkg::KIND_MUL:
                        begin
                            load_item  = 1'b1;
                            k_next     = '0;
                            state_next = ima_pkg::ST_ISSUE;
                        end
                        default:
                        begin
                            load_item  = 1'b1;
                            state_next = ima_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ima_pkg::ST_ISSUE:
            begin
                rd_en   = 1'b1;
                rd_last = (kind_reg != ima_pkg::KIND_MUL) || (k_ext == cols - 1'b1);
                k_next  = k_reg + 1'b1;
                if (rd_last)
                begin
                    state_next = ima_pkg::ST_DRAIN;
                end
            end
            ima_pkg::ST_DRAIN:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = ima_pkg::ST_DONE;
                end
            end
            ima_pkg::ST_DONE:
            begin
                if (!out_vld_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ima_pkg::ST_IDLE;
                end
            end
            default: state_next = ima_pkg::ST_IDLE;
        endcase
    end

    // Store A: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= q_entry.value;
        end
        if (rd_en)
        begin
            a_rd_reg <= mem_a[a_addr];
        end
    end

    // Store B: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= q_entry.value;
        end
        if (rd_en)
        begin
            b_rd_reg <= mem_b[b_addr];
        end
    end

    // Item fields, element operation and accumulation.
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            kind_reg <= q_entry.kind;
            row_reg  <= q_entry.row;
            col_reg  <= q_entry.col;
            rng_reg  <= q_entry.in_range;
        end
        if (s1_vld_reg)
        begin
            unique case (kind_reg)
                ima_pkg::KIND_SUB: prod_reg <= a_rd_reg - b_rd_reg;
                ima_pkg::KIND_MUL: prod_reg <= a_rd_reg * b_rd_reg;
                default:           prod_reg <= a_rd_reg + b_rd_reg;
            endcase
        end
        if (load_item)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (load_out)
        begin
            out_data_reg <= acc_reg;
            out_rng_reg  <= rng_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ima_pkg::ST_IDLE;
            k_reg       <= '0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            s1_vld_reg  <= rd_en;
            s1_last_reg <= rd_last;
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_data_reg;
    assign in_range     = out_rng_reg;

    `IMA_ASSERT(back_k_bound, (state_reg == ima_pkg::ST_ISSUE) |-> (k_ext < cols), "Inner index ran past the column count.")
    `IMA_ASSERT(back_idle_empty, (state_reg == ima_pkg::ST_IDLE) |-> (!s1_vld_reg && !s2_vld_reg), "Pipeline busy while the sequencer is idle.")
    `IMA_ASSERT(back_no_rw_clash, !(rd_en && (wr_a || wr_b)), "Store written while a computation reads it.")
    `IMA_ASSERT_NEXT(back_read_pipe, rd_en, s1_vld_reg, "Read data stage missed a read.")

endmodule

// ===== design/integer_matrix_alu_core.sv =====
// Top level of the integer matrix ALU: register port and the front, queue and back ends.
//
//  Channel  Signals                               Direction  Carries
//  item     item_valid/item_ready, cmd..value     in         load or compute request
//  result   result_valid/result_ready, result     out        C(row,col) and in_range
//  config   psel, penable, pwrite, paddr, pwdata  in         operation, row_count, col_count
//
// A write item is stored in the cycle it leaves the queue, and the back end stays idle.
// An add or subtract item reads one element of each store; a product is computed by
// the single multiply-accumulate unit that steps one inner index per cycle.
// The two-entry queue takes items until full while the back end computes or a result waits.
// Reset clears control state only; matrix stores hold unknown values until written.
module integer_matrix_alu_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [1:0]                  cmd,
    input  logic [ima_pkg::IDX_W-1:0]   row,
    input  logic [ima_pkg::IDX_W-1:0]   col,
    input  logic signed [ima_pkg::DATA_W-1:0] value,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [ima_pkg::DATA_W-1:0] result,
    output logic                        in_range,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ima_pkg::PADDR_W-1:0] paddr,
    input  logic [ima_pkg::PDATA_W-1:0] pwdata,
    output logic [ima_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [ima_pkg::OP_W-1:0]      op_reg;
    logic [ima_pkg::DIM_W-1:0]     row_count_reg;
    logic [ima_pkg::DIM_W-1:0]     col_count_reg;
    logic                          cfg_wr;
    logic [ima_pkg::REG_IDX_W-1:0] reg_idx;
    ima_pkg::dims_t                dims;
    logic                          q_push;
    logic                          q_full;
    logic                          q_valid;
    logic                          q_pop;
    ima_pkg::entry_t               q_in;
    ima_pkg::entry_t               q_out;
    logic [ima_pkg::DATA_W-1:0]    back_result;

    // Register port decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ima_pkg::PADDR_W-1:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= ima_pkg::OP_ADD;
            row_count_reg <= ima_pkg::DIM_RESET;
            col_count_reg <= ima_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ima_pkg::REG_OPERATION: op_reg        <= pwdata[ima_pkg::OP_W-1:0];
                ima_pkg::REG_ROW_COUNT: row_count_reg <= pwdata[ima_pkg::DIM_W-1:0];
                ima_pkg::REG_COL_COUNT: col_count_reg <= pwdata[ima_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (reg_idx)
            ima_pkg::REG_OPERATION:
                prdata = {{(ima_pkg::PDATA_W - ima_pkg::OP_W){1'b0}}, op_reg};
            ima_pkg::REG_ROW_COUNT:
                prdata = {{(ima_pkg::PDATA_W - ima_pkg::DIM_W){1'b0}}, row_count_reg};
            ima_pkg::REG_COL_COUNT:
                prdata = {{(ima_pkg::PDATA_W - ima_pkg::DIM_W){1'b0}}, col_count_reg};
            default:
                prdata = '0;
        endcase
    end

    // Sizes clamped to the store dimension.
    assign dims.op   = op_reg;
    assign dims.rows = (row_count_reg > ima_pkg::DIM_LIMIT) ? ima_pkg::DIM_LIMIT : row_count_reg;
    assign dims.cols = (col_count_reg > ima_pkg::DIM_LIMIT) ? ima_pkg::DIM_LIMIT : col_count_reg;

    ima_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .row        (row),
        .col        (col),
        .value      (value),
        .dims       (dims),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    ima_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .entry_out (q_out),
        .pop       (q_pop)
    );

    ima_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_out),
        .q_pop        (q_pop),
        .cols         (dims.cols),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (back_result),
        .in_range     (in_range)
    );

    assign result = back_result;

endmodule

// ===== tb/tb_integer_matrix_alu_core.sv =====
// Testbench for integer_matrix_alu_core: element loads and computes checked against a predictor.
`timescale 1ns / 1ps

module tb_integer_matrix_alu_core;

    // Codes outside the defined sets, used to check that they are handled.
    localparam logic [1:0]               CMD_NONE = 2'd3;
    localparam logic [ima_pkg::OP_W-1:0] OP_NONE  = 2'd3;

    localparam int IDLE_PCT       = 19;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_AT        = 20;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 10;

    // One load or compute item as it crosses the input channel.
    typedef struct packed {
        logic [1:0]                 cmd;
        logic [ima_pkg::IDX_W-1:0]  row;
        logic [ima_pkg::IDX_W-1:0]  col;
        logic [ima_pkg::DATA_W-1:0] value;
    } mat_item_t;

    // One predicted element of C.
    typedef struct packed {
        logic [ima_pkg::DATA_W-1:0] elem;
        logic                       ok;
    } elem_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              item_valid = 1'b0;
    logic                              item_ready;
    logic [1:0]                        cmd = '0;
    logic [ima_pkg::IDX_W-1:0]         row = '0;
    logic [ima_pkg::IDX_W-1:0]         col = '0;
    logic signed [ima_pkg::DATA_W-1:0] value = '0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic signed [ima_pkg::DATA_W-1:0] result;
    logic                              in_range;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [ima_pkg::PADDR_W-1:0]       paddr = '0;
    logic [ima_pkg::PDATA_W-1:0]       pwdata = '0;
    logic [ima_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;

    // Predictor state: both stores and the active register values.
    logic [ima_pkg::DATA_W-1:0] mat_a [ima_pkg::MEM_DEPTH];
    logic [ima_pkg::DATA_W-1:0] mat_b [ima_pkg::MEM_DEPTH];
    logic [ima_pkg::OP_W-1:0]   cfg_op = ima_pkg::OP_ADD;
    logic [ima_pkg::DIM_W-1:0]  cfg_rows = ima_pkg::DIM_RESET;
    logic [ima_pkg::DIM_W-1:0]  cfg_cols = ima_pkg::DIM_RESET;

    // Elements loaded so far by the item generator, flagged by position.
    bit gen_a_set [ima_pkg::MEM_DEPTH];
    bit gen_b_set [ima_pkg::MEM_DEPTH];

    mat_item_t pending_items [$];
    elem_t     expected_elems [$];
    mat_item_t next_item;
    elem_t     want;

    bit no_idle = 1'b0;
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_flagged = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Settings of the random phases.
    logic [ima_pkg::OP_W-1:0]  ph_op   [NUM_PHASES] = '{ima_pkg::OP_MUL, ima_pkg::OP_ADD,
                                                        ima_pkg::OP_SUB, ima_pkg::OP_MUL,
                                                        ima_pkg::OP_MUL, ima_pkg::OP_ADD,
                                                        OP_NONE, ima_pkg::OP_SUB,
                                                        ima_pkg::OP_MUL, ima_pkg::OP_MUL};
    logic [ima_pkg::DIM_W-1:0] ph_rows [NUM_PHASES] = '{5'd16, 5'd4, 5'd16, 5'd3, 5'd31,
                                                        5'd1, 5'd8, 5'd0, 5'd9, 5'd16};
    logic [ima_pkg::DIM_W-1:0] ph_cols [NUM_PHASES] = '{5'd16, 5'd7, 5'd1, 5'd5, 5'd20,
                                                        5'd16, 5'd8, 5'd9, 5'd2, 5'd16};
    int                        ph_len  [NUM_PHASES] = '{60, 35, 35, 40, 40, 30, 20, 20, 35, 30};

    integer_matrix_alu_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .in_range     (in_range),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    // Sizes above the store are clamped to it.
    function automatic int eff_dim(input logic [ima_pkg::DIM_W-1:0] n);
        return (n > ima_pkg::DIM_LIMIT) ? ima_pkg::MAX_DIM : int'(n);
    endfunction

    // Update the stores for a load, or predict the element for a compute.
    task automatic apply_item(input mat_item_t it);
        int    rows_e;
        int    cols_e;
        int    k;
        elem_t e;
        rows_e = eff_dim(cfg_rows);
        cols_e = eff_dim(cfg_cols);
        case (it.cmd)
            ima_pkg::CMD_WR_A: mat_a[{it.row, it.col}] = it.value;
            ima_pkg::CMD_WR_B: mat_b[{it.row, it.col}] = it.value;
            ima_pkg::CMD_COMPUTE:
            begin
                e.ok = (int'(it.row) < rows_e) && (int'(it.col) < cols_e);
                e.elem = '0;
                if (e.ok)
                begin
                    case (cfg_op)
                        ima_pkg::OP_ADD:
                            e.elem = mat_a[{it.row, it.col}] + mat_b[{it.row, it.col}];
                        ima_pkg::OP_SUB:
                            e.elem = mat_a[{it.row, it.col}] - mat_b[{it.row, it.col}];
                        ima_pkg::OP_MUL:
                        begin
                            for (k = 0; k < cols_e; k++)
                                e.elem += mat_a[{it.row, 4'(k)}] * mat_b[{4'(k), it.col}];
                        end
                        default: e.elem = '0;
                    endcase
                end
                expected_elems.push_back(e);
            end
            default: ;
        endcase
    endtask

    // Values with the sign and carry extremes and small values mixed into full random words.
    function automatic logic [ima_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return ima_pkg::DATA_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] c, input int r, input int k,
                             input logic [ima_pkg::DATA_W-1:0] v);
        mat_item_t it;
        it = '{c, 4'(r), 4'(k), v};
        if (c == ima_pkg::CMD_WR_A)
            gen_a_set[{it.row, it.col}] = 1'b1;
        if (c == ima_pkg::CMD_WR_B)
            gen_b_set[{it.row, it.col}] = 1'b1;
        pending_items.push_back(it);
    endtask

    // A compute never reads an element that was not loaded: missing operands
    // are loaded first with random values.
    task automatic push_compute(input int r, input int c);
        int rows_e;
        int cols_e;
        int k;
        rows_e = eff_dim(cfg_rows);
        cols_e = eff_dim(cfg_cols);
        if (r < rows_e && c < cols_e)
        begin
            if (cfg_op == ima_pkg::OP_ADD || cfg_op == ima_pkg::OP_SUB)
            begin
                if (!gen_a_set[r * ima_pkg::MAX_DIM + c])
                    push_item(ima_pkg::CMD_WR_A, r, c, rand_value());
                if (!gen_b_set[r * ima_pkg::MAX_DIM + c])
                    push_item(ima_pkg::CMD_WR_B, r, c, rand_value());
            end
            else if (cfg_op == ima_pkg::OP_MUL)
            begin
                for (k = 0; k < cols_e; k++)
                begin
                    if (!gen_a_set[r * ima_pkg::MAX_DIM + k])
                        push_item(ima_pkg::CMD_WR_A, r, k, rand_value());
                    if (!gen_b_set[k * ima_pkg::MAX_DIM + c])
                        push_item(ima_pkg::CMD_WR_B, k, c, rand_value());
                end
            end
        end
        push_item(ima_pkg::CMD_COMPUTE, r, c, $urandom);
    endtask

    task automatic apb_write(input logic [ima_pkg::REG_IDX_W-1:0] idx,
                             input logic [ima_pkg::PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the sender until every item is in and every element is out,
    // then give queued loads time to leave the back end. The check runs on
    // the falling edge so that the driver's updates have settled.
    task automatic drain();
        while (pending_items.size() != 0 || item_valid || expected_elems.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [ima_pkg::OP_W-1:0] op,
                              input logic [ima_pkg::DIM_W-1:0] rows,
                              input logic [ima_pkg::DIM_W-1:0] cols);
        drain();
        apb_write(ima_pkg::REG_OPERATION, ima_pkg::PDATA_W'(op));
        apb_write(ima_pkg::REG_ROW_COUNT, ima_pkg::PDATA_W'(rows));
        apb_write(ima_pkg::REG_COL_COUNT, ima_pkg::PDATA_W'(cols));
        cfg_op   = op;
        cfg_rows = rows;
        cfg_cols = cols;
    endtask

    // Input driver: presents the next pending item, with random gaps unless no_idle is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            cmd        <= '0;
            row        <= '0;
            col        <= '0;
            value      <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                apply_item(mat_item_t'{cmd, row, col, value});
                n_items++;
            end
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_item = pending_items.pop_front();
                    item_valid <= 1'b1;
                    cmd        <= next_item.cmd;
                    row        <= next_item.row;
                    col        <= next_item.col;
                    value      <= next_item.value;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each element in order and stalls at random,
    // once for a long stretch so that the input side backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_elems.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected element: expected none, actual %h/%b",
                             $time, result, in_range);
                end
                else
                begin
                    want = expected_elems.pop_front();
                    if (result !== want.elem)
                    begin
                        errors++;
                        $display("%0t: result mismatch: expected %h, actual %h",
                                 $time, want.elem, result);
                    end
                    if (in_range !== want.ok)
                    begin
                        errors++;
                        $display("%0t: in_range mismatch: expected %b, actual %b",
                                 $time, want.ok, in_range);
                    end
                end
                n_results++;
                if (!in_range)
                    n_flagged++;
                if (n_results == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no handshake in %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL integer_matrix_alu_core");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int p;
        int i;
        int sel;
        int rows_e;
        int cols_e;
        int r;
        int c;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: add with wrap past both signed limits, ignored command code.
        push_item(ima_pkg::CMD_WR_A, 0, 0, 32'h7fff_ffff);
        push_item(ima_pkg::CMD_WR_B, 0, 0, 32'h0000_0001);
        push_item(ima_pkg::CMD_WR_A, 15, 15, 32'h8000_0000);
        push_item(ima_pkg::CMD_WR_B, 15, 15, 32'hffff_ffff);
        push_compute(0, 0);
        push_compute(15, 15);
        push_item(CMD_NONE, 3, 5, 32'hffff_ffff);
        push_compute(0, 15);

        // Subtract across the signed limits.
        set_config(ima_pkg::OP_SUB, 5'd16, 5'd16);
        push_compute(15, 15);
        push_compute(0, 0);

        // One-by-one product; a load outside the used size is still stored.
        set_config(ima_pkg::OP_MUL, 5'd1, 5'd1);
        push_item(ima_pkg::CMD_WR_A, 5, 5, 32'hffff_ffff);
        push_compute(0, 0);
        push_compute(0, 1);
        push_compute(1, 0);

        // Undefined operation code, and sizes above the store.
        set_config(OP_NONE, 5'd31, 5'd31);
        push_compute(15, 15);
        push_compute(5, 5);

        // Zero size: nothing is in range.
        set_config(ima_pkg::OP_ADD, 5'd0, 5'd0);
        push_compute(0, 0);
        push_compute(15, 15);

        // Read back the element loaded outside the used size.
        set_config(ima_pkg::OP_ADD, 5'd16, 5'd16);
        push_compute(5, 5);

        // Random phases, each under its own settings.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_config(ph_op[p], ph_rows[p], ph_cols[p]);
            no_idle = (p == 3);
            rows_e = eff_dim(cfg_rows);
            cols_e = eff_dim(cfg_cols);
            for (i = 0; i < ph_len[p]; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 25)
                    push_item(ima_pkg::CMD_WR_A, $urandom_range(0, 15), $urandom_range(0, 15),
                              rand_value());
                else if (sel < 50)
                    push_item(ima_pkg::CMD_WR_B, $urandom_range(0, 15), $urandom_range(0, 15),
                              rand_value());
                else if (sel < 95)
                begin
                    // Mostly positions inside the used size.
                    if (rows_e > 0 && $urandom_range(0, 9) < 7)
                        r = $urandom_range(0, rows_e - 1);
                    else
                        r = $urandom_range(0, 15);
                    if (cols_e > 0 && $urandom_range(0, 9) < 7)
                        c = $urandom_range(0, cols_e - 1);
                    else
                        c = $urandom_range(0, 15);
                    push_compute(r, c);
                end
                else
                    push_item(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
            end
        end
        no_idle = 1'b0;
        drain();

        $display("Run covered %0d items and %0d elements (%0d out of range)",
                 n_items, n_results, n_flagged);
        $display("under %0d random settings plus the directed cases", NUM_PHASES);
        if (errors == 0)
            $display("PASS integer_matrix_alu_core");
        else
            $display("FAIL integer_matrix_alu_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ima_pkg.sv
design/ima_front.sv
design/ima_queue.sv
design/ima_back.sv
design/integer_matrix_alu_core.sv
tb/tb_integer_matrix_alu_core.sv
